>>> rtl/core/lruk_pkg.sv
// Shared constants, types and the stamp update function of the LRU-K cache policy.
package lruk_pkg;

    localparam int CACHE_ENTRIES = 16;
    localparam int HIST_ENTRIES  = 16;
    localparam int K_MAX         = 4;
    localparam int KEY_BITS      = 32;
    localparam int VALUE_BITS    = 32;
    localparam int STAMP_BITS    = 32;

    localparam int SCAN_LEN  = (CACHE_ENTRIES > HIST_ENTRIES) ? CACHE_ENTRIES : HIST_ENTRIES;
    localparam int SIDX_BITS = (SCAN_LEN > 1) ? $clog2(SCAN_LEN) : 1;
    localparam int CIDX_BITS = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam int HIDX_BITS = (HIST_ENTRIES > 1) ? $clog2(HIST_ENTRIES) : 1;
    localparam int CNT_BITS  = $clog2(K_MAX + 1);
    localparam int USED_BITS = $clog2(CACHE_ENTRIES + 1);
    localparam int K_BITS    = 3;
    localparam int LIM_BITS  = 5;
    localparam int CFG_BITS  = 5;
    localparam int CNT_OUT_BITS = 3;

    typedef enum logic [1:0] {
        FUNC_GET   = 2'd0,
        FUNC_PUT   = 2'd1,
        FUNC_CLEAR = 2'd2,
        FUNC_NOP   = 2'd3
    } func_t;

    typedef enum logic {
        CFG_K_DEPTH     = 1'b0,
        CFG_CACHE_LIMIT = 1'b1
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_SCAN = 2'd1,
        ST_EXEC = 2'd2
    } state_t;

    typedef struct packed {
        logic                 load;
        logic                 scan_en;
        logic [SIDX_BITS-1:0] scan_idx;
        logic                 exec_en;
    } ctrl_t;

    typedef logic [K_MAX-1:0][STAMP_BITS-1:0] stamps_t;

    typedef struct packed {
        stamps_t             st;
        logic [CNT_BITS-1:0] n;
    } stamp_res_t;

    // Append the clock to a stamp list, dropping the oldest stamp once when over k.
    function automatic stamp_res_t take_stamp(stamps_t st, logic [CNT_BITS-1:0] n,
                                              logic [CNT_BITS-1:0] k,
                                              logic [STAMP_BITS-1:0] clk_val);
        stamp_res_t r;
        int i;
        r.st = st;
        r.n  = n;
        if (r.n > CNT_BITS'(K_MAX))
        begin
            r.n = CNT_BITS'(K_MAX);
        end
        if ((({1'b0, r.n} + 1'b1) > {1'b0, k}) && (r.n != '0))
        begin
            for (i = 0; i < K_MAX - 1; i++)
            begin
                if ((i + 1) < int'(r.n))
                begin
                    r.st[i] = r.st[i + 1];
                end
            end
            r.n = r.n - 1'b1;
        end
        if (r.n < CNT_BITS'(K_MAX))
        begin
            for (i = 0; i < K_MAX; i++)
            begin
                if (i == int'(r.n))
                begin
                    r.st[i] = clk_val;
                end
            end
            r.n = r.n + 1'b1;
        end
        return r;
    endfunction

endpackage

>>> rtl/core/lruk_ctrl.sv
// Sequencer that walks the table scan and then issues the update cycle.
module lruk_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    output lruk_pkg::ctrl_t ctrl
);

    lruk_pkg::state_t                 state_reg;
    lruk_pkg::state_t                 state_next;
    logic [lruk_pkg::SIDX_BITS-1:0]   idx_reg;
    logic [lruk_pkg::SIDX_BITS-1:0]   idx_next;
    logic                             last_idx;

    assign last_idx = (idx_reg == lruk_pkg::SIDX_BITS'(lruk_pkg::SCAN_LEN - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lruk_pkg::ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        case (state_reg)
            lruk_pkg::ST_IDLE:
            begin
                idx_next = '0;
                if (start)
                begin
                    state_next = lruk_pkg::ST_SCAN;
                end
            end
            lruk_pkg::ST_SCAN:
            begin
                if (last_idx)
                begin
                    state_next = lruk_pkg::ST_EXEC;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            lruk_pkg::ST_EXEC:
            begin
                state_next = lruk_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = lruk_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        busy          = 1'b0;
        ctrl.load     = 1'b0;
        ctrl.scan_en  = 1'b0;
        ctrl.exec_en  = 1'b0;
        ctrl.scan_idx = idx_reg;
        case (state_reg)
            lruk_pkg::ST_IDLE:
            begin
                ctrl.load = start;
            end
            lruk_pkg::ST_SCAN:
            begin
                busy         = 1'b1;
                ctrl.scan_en = 1'b1;
            end
            lruk_pkg::ST_EXEC:
            begin
                busy         = 1'b1;
                ctrl.exec_en = 1'b1;
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

endmodule

>>> rtl/core/lruk_core.sv
// Cache and history tables with the per-entry scan unit and the update cycle.
module lruk_core
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  lruk_pkg::ctrl_t                    ctrl,
    input  logic [1:0]                         func,
    input  logic [lruk_pkg::KEY_BITS-1:0]      req_key,
    input  logic [lruk_pkg::VALUE_BITS-1:0]    write_value,
    input  logic [lruk_pkg::K_BITS-1:0]        k_depth,
    input  logic [lruk_pkg::LIM_BITS-1:0]      cache_limit,
    output logic                               done,
    output logic                               hit,
    output logic [lruk_pkg::VALUE_BITS-1:0]    read_value,
    output logic                               promoted,
    output logic                               evicted,
    output logic [lruk_pkg::KEY_BITS-1:0]      evicted_key,
    output logic [lruk_pkg::CNT_OUT_BITS-1:0]  access_count
);

    localparam int CE = lruk_pkg::CACHE_ENTRIES;
    localparam int HE = lruk_pkg::HIST_ENTRIES;
    localparam int CB = lruk_pkg::CNT_BITS;
    localparam int CI = lruk_pkg::CIDX_BITS;
    localparam int HI = lruk_pkg::HIDX_BITS;
    localparam int SB = lruk_pkg::STAMP_BITS;

    logic [CE-1:0]                          cache_valid_reg;
    logic [lruk_pkg::KEY_BITS-1:0]          cache_key_reg [CE];
    logic [lruk_pkg::VALUE_BITS-1:0]        cache_value_reg [CE];
    lruk_pkg::stamps_t                      cache_stamps_reg [CE];
    logic [CB-1:0]                          cache_count_reg [CE];
    logic [HE-1:0]                          hist_valid_reg;
    logic [lruk_pkg::KEY_BITS-1:0]          hist_key_reg [HE];
    lruk_pkg::stamps_t                      hist_stamps_reg [HE];
    logic [CB-1:0]                          hist_count_reg [HE];
    logic [SB-1:0]                          clock_reg;

    logic [1:0]                             func_reg;
    logic [lruk_pkg::KEY_BITS-1:0]          key_reg;
    logic [lruk_pkg::VALUE_BITS-1:0]        val_reg;

    logic                                   cfound_reg, hfound_reg, cfree_reg, hfree_reg;
    logic                                   cbest_reg, hbest_reg;
    logic [CI-1:0]                          cidx_reg, cfree_idx_reg, cbest_idx_reg;
    logic [HI-1:0]                          hidx_reg, hfree_idx_reg, hbest_idx_reg;
    logic [SB-1:0]                          cbest_age_reg, hbest_age_reg;
    logic [lruk_pkg::USED_BITS-1:0]         used_reg;

    logic                                   done_reg, hit_reg, prom_reg, ev_reg;
    logic [lruk_pkg::VALUE_BITS-1:0]        rd_reg;
    logic [lruk_pkg::KEY_BITS-1:0]          evkey_reg;
    logic [CB-1:0]                          cnt_reg;

    logic [CI-1:0]                          sc;
    logic [HI-1:0]                          sh;
    logic                                   c_in, h_in;
    logic [SB-1:0]                          c_age, h_age;
    logic [CB-1:0]                          k_eff;
    logic [lruk_pkg::USED_BITS-1:0]         lim_eff;
    logic [HI-1:0]                          h_sel;
    logic [CB-1:0]                          h_base_cnt;
    lruk_pkg::stamp_res_t                   c_res, h_res;
    logic                                   do_evict;
    logic [CI-1:0]                          slot;

    assign sc   = ctrl.scan_idx[CI-1:0];
    assign sh   = ctrl.scan_idx[HI-1:0];
    assign c_in = (int'(ctrl.scan_idx) < CE);
    assign h_in = (int'(ctrl.scan_idx) < HE);
    assign c_age = (clock_reg + 1'b1) - cache_stamps_reg[sc][0];
    assign h_age = clock_reg - hist_stamps_reg[sh][0];

    always_comb
    begin
        if (k_depth == '0)
        begin
            k_eff = CB'(1);
        end
        else if (int'(k_depth) > lruk_pkg::K_MAX)
        begin
            k_eff = CB'(lruk_pkg::K_MAX);
        end
        else
        begin
            k_eff = CB'(k_depth);
        end
        if (cache_limit == '0)
        begin
            lim_eff = lruk_pkg::USED_BITS'(1);
        end
        else if (int'(cache_limit) > CE)
        begin
            lim_eff = lruk_pkg::USED_BITS'(CE);
        end
        else
        begin
            lim_eff = lruk_pkg::USED_BITS'(cache_limit);
        end
    end

    always_comb
    begin
        if (hfound_reg)
        begin
            h_sel = hidx_reg;
        end
        else if (hfree_reg)
        begin
            h_sel = hfree_idx_reg;
        end
        else
        begin
            h_sel = hbest_idx_reg;
        end
        h_base_cnt = hfound_reg ? hist_count_reg[h_sel] : '0;
        c_res = lruk_pkg::take_stamp(cache_stamps_reg[cidx_reg], cache_count_reg[cidx_reg],
                                     k_eff, clock_reg);
        h_res = lruk_pkg::take_stamp(hist_stamps_reg[h_sel], h_base_cnt, k_eff, clock_reg);
        do_evict = (used_reg >= lim_eff) && cbest_reg;
        if (cfree_reg)
        begin
            slot = (do_evict && (cbest_idx_reg < cfree_idx_reg)) ? cbest_idx_reg : cfree_idx_reg;
        end
        else
        begin
            slot = cbest_idx_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            func_reg   <= func;
            key_reg    <= req_key;
            val_reg    <= write_value;
            cfound_reg <= 1'b0;
            hfound_reg <= 1'b0;
            cfree_reg  <= 1'b0;
            hfree_reg  <= 1'b0;
            cbest_reg  <= 1'b0;
            hbest_reg  <= 1'b0;
            used_reg   <= '0;
        end
        if (ctrl.scan_en)
        begin
            if (c_in)
            begin
                if (cache_valid_reg[sc])
                begin
                    used_reg <= used_reg + 1'b1;
                    if (!cfound_reg && (cache_key_reg[sc] == key_reg))
                    begin
                        cfound_reg <= 1'b1;
                        cidx_reg   <= sc;
                    end
                    if (!cbest_reg || (c_age > cbest_age_reg))
                    begin
                        cbest_reg     <= 1'b1;
                        cbest_idx_reg <= sc;
                        cbest_age_reg <= c_age;
                    end
                end
                else if (!cfree_reg)
                begin
                    cfree_reg     <= 1'b1;
                    cfree_idx_reg <= sc;
                end
            end
            if (h_in)
            begin
                if (hist_valid_reg[sh])
                begin
                    if (!hfound_reg && (hist_key_reg[sh] == key_reg))
                    begin
                        hfound_reg <= 1'b1;
                        hidx_reg   <= sh;
                    end
                end
                else if (!hfree_reg)
                begin
                    hfree_reg     <= 1'b1;
                    hfree_idx_reg <= sh;
                end
                if (!hbest_reg || (h_age > hbest_age_reg))
                begin
                    hbest_reg     <= 1'b1;
                    hbest_idx_reg <= sh;
                    hbest_age_reg <= h_age;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cache_valid_reg <= '0;
            hist_valid_reg  <= '0;
            clock_reg       <= '0;
            done_reg        <= 1'b0;
            for (int i = 0; i < CE; i++)
            begin
                cache_count_reg[i] <= '0;
            end
            for (int i = 0; i < HE; i++)
            begin
                hist_count_reg[i] <= '0;
            end
        end
        else
        begin
            done_reg <= ctrl.exec_en;
            if (ctrl.exec_en)
            begin
                hit_reg   <= 1'b0;
                rd_reg    <= '0;
                prom_reg  <= 1'b0;
                ev_reg    <= 1'b0;
                evkey_reg <= '0;
                cnt_reg   <= '0;
                case (func_reg)
                    lruk_pkg::FUNC_GET:
                    begin
                        if (cfound_reg)
                        begin
                            cache_stamps_reg[cidx_reg] <= c_res.st;
                            cache_count_reg[cidx_reg]  <= c_res.n;
                            clock_reg <= clock_reg + 1'b1;
                            hit_reg   <= 1'b1;
                            rd_reg    <= cache_value_reg[cidx_reg];
                            cnt_reg   <= c_res.n;
                        end
                        else if (hfound_reg)
                        begin
                            cnt_reg <= hist_count_reg[hidx_reg];
                        end
                    end
                    lruk_pkg::FUNC_PUT:
                    begin
                        clock_reg <= clock_reg + 1'b1;
                        if (cfound_reg)
                        begin
                            cache_value_reg[cidx_reg]  <= val_reg;
                            cache_stamps_reg[cidx_reg] <= c_res.st;
                            cache_count_reg[cidx_reg]  <= c_res.n;
                            hit_reg <= 1'b1;
                            cnt_reg <= c_res.n;
                        end
                        else
                        begin
                            cnt_reg <= h_res.n;
                            if (h_res.n >= k_eff)
                            begin
                                if (do_evict)
                                begin
                                    cache_valid_reg[cbest_idx_reg] <= 1'b0;
                                    cache_count_reg[cbest_idx_reg] <= '0;
                                    ev_reg    <= 1'b1;
                                    evkey_reg <= cache_key_reg[cbest_idx_reg];
                                end
                                cache_valid_reg[slot]  <= 1'b1;
                                cache_key_reg[slot]    <= key_reg;
                                cache_value_reg[slot]  <= val_reg;
                                cache_stamps_reg[slot] <= h_res.st;
                                cache_count_reg[slot]  <= h_res.n;
                                hist_valid_reg[h_sel]  <= 1'b0;
                                hist_count_reg[h_sel]  <= '0;
                                prom_reg <= 1'b1;
                            end
                            else
                            begin
                                hist_valid_reg[h_sel]  <= 1'b1;
                                hist_key_reg[h_sel]    <= key_reg;
                                hist_stamps_reg[h_sel] <= h_res.st;
                                hist_count_reg[h_sel]  <= h_res.n;
                            end
                        end
                    end
                    lruk_pkg::FUNC_CLEAR:
                    begin
                        cache_valid_reg <= '0;
                        hist_valid_reg  <= '0;
                        clock_reg       <= '0;
                        for (int i = 0; i < CE; i++)
                        begin
                            cache_count_reg[i] <= '0;
                        end
                        for (int i = 0; i < HE; i++)
                        begin
                            hist_count_reg[i] <= '0;
                        end
                    end
                    default:
                    begin
                        cnt_reg <= '0;
                    end
                endcase
            end
        end
    end

    assign done         = done_reg;
    assign hit          = hit_reg;
    assign read_value   = rd_reg;
    assign promoted     = prom_reg;
    assign evicted      = ev_reg;
    assign evicted_key  = evkey_reg;
    assign access_count = lruk_pkg::CNT_OUT_BITS'(cnt_reg);

endmodule

>>> rtl/core/lru_k_cache_policy.sv
// Top level of the LRU-K cache replacement policy block.
//  channel   signals                                         handshake
//  request   func, req_key, write_value                      start high, busy low
//  result    hit, read_value, promoted, evicted,             done, one cycle
//            evicted_key, access_count
//  config    cfg_we, cfg_index, cfg_data                     cfg_we high
// Each transaction scans the table entries in turn, then runs the update cycle, after which
// the result is registered. The scan walks both tables together, one entry per cycle.
// Reset clears all valid bits and counts at once, with no sweep.
// The result shows for one cycle with done; the receiver cannot stall.
module lru_k_cache_policy
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [1:0]                         func,
    input  logic [lruk_pkg::KEY_BITS-1:0]      req_key,
    input  logic [lruk_pkg::VALUE_BITS-1:0]    write_value,
    output logic                               done,
    output logic                               hit,
    output logic [lruk_pkg::VALUE_BITS-1:0]    read_value,
    output logic                               promoted,
    output logic                               evicted,
    output logic [lruk_pkg::KEY_BITS-1:0]      evicted_key,
    output logic [lruk_pkg::CNT_OUT_BITS-1:0]  access_count,
    input  logic                               cfg_we,
    input  logic                               cfg_index,
    input  logic [lruk_pkg::CFG_BITS-1:0]      cfg_data
);

    lruk_pkg::ctrl_t                  ctrl;
    logic [lruk_pkg::K_BITS-1:0]      k_depth_reg;
    logic [lruk_pkg::LIM_BITS-1:0]    cache_limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_depth_reg     <= lruk_pkg::K_BITS'(2);
            cache_limit_reg <= lruk_pkg::LIM_BITS'(16);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lruk_pkg::CFG_K_DEPTH:
                begin
                    k_depth_reg <= cfg_data[lruk_pkg::K_BITS-1:0];
                end
                lruk_pkg::CFG_CACHE_LIMIT:
                begin
                    cache_limit_reg <= cfg_data[lruk_pkg::LIM_BITS-1:0];
                end
                default:
                begin
                    k_depth_reg <= k_depth_reg;
                end
            endcase
        end
    end

    lruk_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .ctrl  (ctrl)
    );

    lruk_core u_core
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .func         (func),
        .req_key      (req_key),
        .write_value  (write_value),
        .k_depth      (k_depth_reg),
        .cache_limit  (cache_limit_reg),
        .done         (done),
        .hit          (hit),
        .read_value   (read_value),
        .promoted     (promoted),
        .evicted      (evicted),
        .evicted_key  (evicted_key),
        .access_count (access_count)
    );

    assert property (@(posedge clk) disable iff (!rst_n) done |-> $past(busy))
        else $error("result without a transaction in progress");
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("accepted transaction did not start");
    assert property (@(posedge clk) disable iff (!rst_n) (done && evicted) |-> promoted)
        else $error("eviction without promotion");
    assert property (@(posedge clk) disable iff (!rst_n) (done && !hit) |-> (read_value == '0))
        else $error("read value on a miss");

endmodule
